FILE: hw/rtl/dda_pkg.sv
`default_nettype none

package dda_pkg;

  // Default geometry
  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Configuration port
  localparam int unsigned COLOR_BITS    = 4;
  localparam int unsigned CFG_ADDR_BITS = 4;

  localparam logic [CFG_ADDR_BITS-1:0] REG_START_COLOR = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_LINE_COLOR  = CFG_ADDR_BITS'(1);

  localparam logic [COLOR_BITS-1:0] START_COLOR_RST = COLOR_BITS'(4);
  localparam logic [COLOR_BITS-1:0] LINE_COLOR_RST  = COLOR_BITS'(1);

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/dda_ifs.sv
`default_nettype none

// Line command channel
interface dda_in_if #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

// Pixel channel
interface dda_out_if #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [COORD_BITS-1:0]           pixel_x;
  logic [COORD_BITS-1:0]           pixel_y;
  logic [dda_pkg::COLOR_BITS-1:0]  color;
  logic                            last_pixel;

  modport source (output valid, pixel_x, pixel_y, color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, color, last_pixel, output ready);
endinterface

// Register write channel
interface dda_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dda_pkg::CFG_ADDR_BITS-1:0] index;
  logic [dda_pkg::COLOR_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dda_line_rasterizer.sv
`default_nettype none

// Channel  Dir  Payload                                   Transfer when
// -------  ---  ----------------------------------------  ----------------
// in_i     in   kind, x_start, y_start, x_end, y_end      valid && ready
// out_o    out  pixel_x, pixel_y, color, last_pixel       valid && ready
// cfg_i    in   index, data (start_color, line_color)     valid && ready
//
// Ticks stream at one per cycle while pixels drain.
// A start of nonzero length runs one restoring divider, one quotient bit
// per cycle, for x then y, then the first pixel is loaded. A zero-length
// start loads its single last pixel without a division.
// Reset clears the sequencer to idle and loads the color registers.
// A one-entry output register holds a pixel until it is taken; input is
// held off during the division and the first-pixel load, and while that
// register is full and not being drained.
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  dda_in_if.sink      in_i,
  dda_out_if.source   out_o,
  dda_cfg_if.sink     cfg_i
);
  import dda_pkg::*;

  localparam int unsigned AW    = COORD_BITS + FRAC_BITS;
  localparam int unsigned SW    = AW + 1;
  localparam int unsigned CNT_W = $clog2(AW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AW - 1);

  state_e state_q, state_d;

  logic [COLOR_BITS-1:0] start_color_q, line_color_q;

  logic [AW-1:0]         x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic [SW-1:0]         x_step_q, x_step_d, y_step_q, y_step_d;
  logic [COORD_BITS-1:0] steps_left_q, steps_left_d;
  logic [COORD_BITS-1:0] n_q, n_d, mag_y_q, mag_y_d;
  logic                  neg_x_q, neg_x_d, neg_y_q, neg_y_d;

  // Divider state
  logic [AW-1:0]         dvd_q, dvd_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Output register
  logic                  ov_q, ov_d;
  logic [COORD_BITS-1:0] opx_q, opx_d, opy_q, opy_d;
  logic [COLOR_BITS-1:0] ocol_q, ocol_d;
  logic                  olast_q, olast_d;

  logic out_free, in_fire, is_start, div_last;
  logic [COORD_BITS-1:0] adx, ady, n_new;
  logic [COORD_BITS:0]   rem_sh;
  logic                  q_bit;
  logic [AW-1:0]         quot;
  logic [SW-1:0]         quot_ext, quot_sgn;
  logic [AW-1:0]         x_sum, y_sum;

  assign out_free   = !ov_q || out_o.ready;
  assign in_i.ready = ((state_q == ST_IDLE) || (state_q == ST_RUN)) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_start   = (in_i.kind == KIND_START);
  assign div_last   = (cnt_q == CNT_LAST);

  // Endpoint deltas and line length
  assign adx   = (in_i.x_end >= in_i.x_start) ? in_i.x_end - in_i.x_start
                                              : in_i.x_start - in_i.x_end;
  assign ady   = (in_i.y_end >= in_i.y_start) ? in_i.y_end - in_i.y_start
                                              : in_i.y_start - in_i.y_end;
  assign n_new = (adx > ady) ? adx : ady;

  // Shared restoring divider step: one quotient bit
  assign rem_sh   = {rem_q, dvd_q[AW-1]};
  assign q_bit    = (rem_sh >= {1'b0, n_q});
  assign quot     = {dvd_q[AW-2:0], q_bit};
  assign quot_ext = {1'b0, quot};
  assign quot_sgn = (state_q == ST_DIV_X) ? (neg_x_q ? -quot_ext : quot_ext)
                                          : (neg_y_q ? -quot_ext : quot_ext);

  // Accumulator adders, wrapping at the accumulator width
  assign x_sum = x_acc_q + x_step_q[AW-1:0];
  assign y_sum = y_acc_q + y_step_q[AW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_RUN: begin
        if (in_fire) begin
          if (is_start) begin
            state_d = (n_new == '0) ? ST_IDLE : ST_DIV_X;
          end else if (state_q == ST_RUN && steps_left_q == COORD_BITS'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV_X: if (div_last) state_d = ST_DIV_Y;
      ST_DIV_Y: if (div_last) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_RUN;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register
  always_comb begin
    x_acc_d      = x_acc_q;
    y_acc_d      = y_acc_q;
    x_step_d     = x_step_q;
    y_step_d     = y_step_q;
    steps_left_d = steps_left_q;
    n_d          = n_q;
    mag_y_d      = mag_y_q;
    neg_x_d      = neg_x_q;
    neg_y_d      = neg_y_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    ov_d         = ov_q && !out_o.ready;
    opx_d        = opx_q;
    opy_d        = opy_q;
    ocol_d       = ocol_q;
    olast_d      = olast_q;

    case (state_q)
      ST_IDLE, ST_RUN: begin
        if (in_fire && is_start) begin
          x_acc_d      = {in_i.x_start, {FRAC_BITS{1'b0}}};
          y_acc_d      = {in_i.y_start, {FRAC_BITS{1'b0}}};
          n_d          = n_new;
          steps_left_d = n_new;
          mag_y_d      = ady;
          neg_x_d      = (in_i.x_end < in_i.x_start);
          neg_y_d      = (in_i.y_end < in_i.y_start);
          dvd_d        = {adx, {FRAC_BITS{1'b0}}};
          rem_d        = '0;
          cnt_d        = '0;
          if (n_new == '0) begin
            // Zero length: single last pixel at the start point
            x_step_d = '0;
            y_step_d = '0;
            ov_d     = 1'b1;
            opx_d    = in_i.x_start;
            opy_d    = in_i.y_start;
            ocol_d   = start_color_q;
            olast_d  = 1'b1;
          end
        end else if (in_fire && state_q == ST_RUN) begin
          // Tick: advance and emit
          x_acc_d      = x_sum;
          y_acc_d      = y_sum;
          steps_left_d = steps_left_q - COORD_BITS'(1);
          ov_d         = 1'b1;
          opx_d        = x_sum[AW-1:FRAC_BITS];
          opy_d        = y_sum[AW-1:FRAC_BITS];
          ocol_d       = line_color_q;
          olast_d      = (steps_left_q == COORD_BITS'(1));
        end
      end
      ST_DIV_X, ST_DIV_Y: begin
        rem_d = q_bit ? COORD_BITS'(rem_sh - {1'b0, n_q}) : rem_sh[COORD_BITS-1:0];
        dvd_d = quot;
        cnt_d = cnt_q + CNT_W'(1);
        if (div_last) begin
          cnt_d = '0;
          rem_d = '0;
          if (state_q == ST_DIV_X) begin
            x_step_d = quot_sgn;
            dvd_d    = {mag_y_q, {FRAC_BITS{1'b0}}};
          end else begin
            y_step_d = quot_sgn;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          opx_d   = x_acc_q[AW-1:FRAC_BITS];
          opy_d   = y_acc_q[AW-1:FRAC_BITS];
          ocol_d  = start_color_q;
          olast_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ov_q          <= 1'b0;
      steps_left_q  <= '0;
      cnt_q         <= '0;
      start_color_q <= START_COLOR_RST;
      line_color_q  <= LINE_COLOR_RST;
    end else begin
      state_q      <= state_d;
      ov_q         <= ov_d;
      steps_left_q <= steps_left_d;
      cnt_q        <= cnt_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_START_COLOR: start_color_q <= cfg_i.data;
          REG_LINE_COLOR:  line_color_q  <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_acc_q  <= x_acc_d;
    y_acc_q  <= y_acc_d;
    x_step_q <= x_step_d;
    y_step_q <= y_step_d;
    n_q      <= n_d;
    mag_y_q  <= mag_y_d;
    neg_x_q  <= neg_x_d;
    neg_y_q  <= neg_y_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    opx_q    <= opx_d;
    opy_q    <= opy_d;
    ocol_q   <= ocol_d;
    olast_q  <= olast_d;
  end

  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = ov_q;
  assign out_o.pixel_x    = opx_q;
  assign out_o.pixel_y    = opy_q;
  assign out_o.color      = ocol_q;
  assign out_o.last_pixel = olast_q;

endmodule

`default_nettype wire

FILE: dv/dda_pixel_checker.sv
`timescale 1ns / 1ps

module dda_pixel_checker
  import dda_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  dda_in_if            cmd_i,
  dda_out_if           pix_i,
  dda_cfg_if           cfg_i,
  output int unsigned  err_cnt_o,
  output int unsigned  pending_o
);

  localparam int unsigned CB     = COORD_BITS_DEF;
  localparam int unsigned FB     = FRAC_BITS_DEF;
  localparam int unsigned ACC_W  = CB + FB;
  localparam int unsigned STEP_W = ACC_W + 1;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [CB-1:0]         x;
    logic [CB-1:0]         y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  // Predicted line walker state
  logic [ACC_W-1:0]      x_pos, y_pos;
  logic [STEP_W-1:0]     x_inc, y_inc;
  logic [CB-1:0]         px_left;
  logic                  line_busy;
  logic [COLOR_BITS-1:0] start_col, line_col;

  pixel_t      pixel_q[$];
  int unsigned err_cnt;

  // Signed per-pixel increment, quotient truncated toward zero
  function automatic logic [STEP_W-1:0] axis_increment(logic [CB-1:0] from_c,
                                                       logic [CB-1:0] to_c,
                                                       logic [CB-1:0] span);
    logic [CB-1:0]     mag;
    logic [STEP_W-1:0] quo;
    mag = (to_c >= from_c) ? to_c - from_c : from_c - to_c;
    quo = (STEP_W'(mag) << FB) / STEP_W'(span);
    if (to_c < from_c) quo = -quo;
    return quo;
  endfunction

  task automatic push_pixel(logic [COLOR_BITS-1:0] col, logic last);
    pixel_t px;
    px.x     = x_pos[ACC_W-1:FB];
    px.y     = y_pos[ACC_W-1:FB];
    px.color = col;
    px.last  = last;
    pixel_q.push_back(px);
  endtask

  // Advance the predicted walker by one accepted command
  task automatic predict_cmd();
    logic [CB-1:0] adx, ady, span;
    if (cmd_i.kind == KIND_START) begin
      adx = (cmd_i.x_end >= cmd_i.x_start) ? cmd_i.x_end - cmd_i.x_start
                                           : cmd_i.x_start - cmd_i.x_end;
      ady = (cmd_i.y_end >= cmd_i.y_start) ? cmd_i.y_end - cmd_i.y_start
                                           : cmd_i.y_start - cmd_i.y_end;
      span  = (adx > ady) ? adx : ady;
      x_pos = {cmd_i.x_start, {FB{1'b0}}};
      y_pos = {cmd_i.y_start, {FB{1'b0}}};
      if (span == '0) begin
        x_inc     = '0;
        y_inc     = '0;
        px_left   = '0;
        line_busy = 1'b0;
        push_pixel(start_col, 1'b1);
      end else begin
        x_inc     = axis_increment(cmd_i.x_start, cmd_i.x_end, span);
        y_inc     = axis_increment(cmd_i.y_start, cmd_i.y_end, span);
        px_left   = span;
        line_busy = 1'b1;
        push_pixel(start_col, 1'b0);
      end
    end else if (line_busy) begin
      x_pos   = x_pos + x_inc[ACC_W-1:0];
      y_pos   = y_pos + y_inc[ACC_W-1:0];
      px_left = px_left - CB'(1);
      if (px_left == '0) begin
        line_busy = 1'b0;
        push_pixel(line_col, 1'b1);
      end else begin
        push_pixel(line_col, 1'b0);
      end
    end
  endtask

  // Compare one pixel transfer against the oldest prediction
  task automatic check_pixel();
    pixel_t want, got;
    got.x     = pix_i.pixel_x;
    got.y     = pix_i.pixel_y;
    got.color = pix_i.color;
    got.last  = pix_i.last_pixel;
    if (pixel_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0b",
                 $realtime, got.x, got.y, got.color, got.last);
    end else begin
      want = pixel_q.pop_front();
      if (want.x !== got.x || want.y !== got.y || want.color !== got.color ||
          want.last !== got.last) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $write("%0t: pixel mismatch exp x=%0d y=%0d color=%0d last=%0b,",
                 $realtime, want.x, want.y, want.color, want.last);
          $display(" got x=%0d y=%0d color=%0d last=%0b",
                   got.x, got.y, got.color, got.last);
        end
      end
    end
  endtask

  // Sample transfers: drain pixels first, then apply writes and commands
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_pos     = '0;
      y_pos     = '0;
      x_inc     = '0;
      y_inc     = '0;
      px_left   = '0;
      line_busy = 1'b0;
      start_col = START_COLOR_RST;
      line_col  = LINE_COLOR_RST;
      pixel_q.delete();
      err_cnt   = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (pix_i.valid && pix_i.ready) check_pixel();
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_START_COLOR) start_col = cfg_i.data;
        else if (cfg_i.index == REG_LINE_COLOR) line_col = cfg_i.data;
      end
      if (cmd_i.valid && cmd_i.ready) predict_cmd();
      err_cnt_o <= err_cnt;
      pending_o <= pixel_q.size();
    end
  end

endmodule

FILE: dv/tb_dda_line_rasterizer.sv
`timescale 1ns / 1ps

module tb_dda_line_rasterizer;
  import dda_pkg::*;

  localparam int unsigned CB         = COORD_BITS_DEF;
  localparam int unsigned CMAX       = (1 << CB) - 1;
  localparam logic [CB-1:0] C_MAX    = CB'(CMAX);
  localparam int unsigned SETTLE     = 64;
  localparam int unsigned CYCLE_MAX  = 500000;
  localparam int unsigned PHASE_CMDS = 132;
  localparam int unsigned HOLD_AFTER = 200;
  localparam int unsigned HOLD_LEN   = 400;

  logic clk_i;
  logic rst_ni;

  dda_in_if  in_if ();
  dda_out_if out_if ();
  dda_cfg_if cfg_if ();

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned cmd_cnt;
  int unsigned pix_cnt;
  int unsigned burst_left;
  int unsigned cycle_cnt;

  dda_line_rasterizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  dda_pixel_checker i_pixel_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (in_if),
    .pix_i     (out_if),
    .cfg_i     (cfg_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  // Clock and one reset pulse
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Count pixel transfers
  initial pix_cnt = 0;
  always @(posedge clk_i)
    if (out_if.valid && out_if.ready) pix_cnt++;

  // Pixel sink: random stall windows plus one long hold-off
  initial begin : p_sink
    int unsigned mode, win, hold_left;
    bit          held;
    out_if.ready = 1'b0;
    win          = 0;
    hold_left    = 0;
    held         = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && pix_cnt >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        if (win == 0) begin
          mode = $urandom_range(0, 3);
          win  = $urandom_range(20, 120);
        end
        win--;
        case (mode)
          0:       out_if.ready = 1'b1;
          1:       out_if.ready = 1'($urandom_range(0, 1));
          2:       out_if.ready = ($urandom_range(0, 3) == 0);
          default: out_if.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one command in bursts separated by random gaps
  task automatic send_cmd(logic kind, logic [CB-1:0] xs, logic [CB-1:0] ys,
                          logic [CB-1:0] xe, logic [CB-1:0] ye);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid = 1'b0;
      end
    end
    @(negedge clk_i);
    in_if.valid   = 1'b1;
    in_if.kind    = kind;
    in_if.x_start = xs;
    in_if.y_start = ys;
    in_if.x_end   = xe;
    in_if.y_end   = ye;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    cmd_cnt++;
  endtask

  // Tick with junk endpoints, which the block must ignore
  task automatic send_tick();
    send_cmd(KIND_TICK, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [COLOR_BITS-1:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Stop offering, wait for every predicted pixel, then let a division finish
  task automatic drain_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Coordinate biased toward the edges of the screen
  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return CMAX;
      default: return $urandom_range(0, CMAX);
    endcase
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > int'(CMAX)) return CMAX;
    return v;
  endfunction

  // One line: start, then ticks to finish, abandon it or overrun into idle
  task automatic run_line();
    int sel, xs, ys, xe, ye, lim, span, nticks;
    sel = $urandom_range(0, 99);
    xs  = pick_coord();
    ys  = pick_coord();
    if (sel < 10) begin
      xe = pick_coord();
      ye = pick_coord();
    end else begin
      lim = (sel < 30) ? 60 : 8;
      xe  = clamp_coord(xs + $urandom_range(0, 2 * lim) - lim);
      ye  = clamp_coord(ys + $urandom_range(0, 2 * lim) - lim);
    end
    span = (xe > xs) ? xe - xs : xs - xe;
    if (((ye > ys) ? ye - ys : ys - ye) > span) span = (ye > ys) ? ye - ys : ys - ye;
    if (sel < 10) nticks = $urandom_range(0, 12);
    else begin
      case ($urandom_range(0, 9))
        0:       nticks = $urandom_range(0, span);
        1:       nticks = span + $urandom_range(1, 3);
        default: nticks = span;
      endcase
    end
    send_cmd(KIND_START, CB'(xs), CB'(ys), CB'(xe), CB'(ye));
    repeat (nticks) send_tick();
  endtask

  // Stimulus and verdict
  initial begin : p_stim
    int unsigned phase, base;
    in_if.valid   = 1'b0;
    in_if.kind    = KIND_START;
    in_if.x_start = '0;
    in_if.y_start = '0;
    in_if.x_end   = '0;
    in_if.y_end   = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_START_COLOR;
    cfg_if.data   = '0;
    cmd_cnt       = 0;
    burst_left    = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: idle tick, zero-length lines, diagonals, abandon, short lines
    send_tick();
    send_cmd(KIND_START, '0, '0, '0, '0);
    send_cmd(KIND_START, C_MAX, C_MAX, C_MAX, C_MAX);
    send_tick();
    send_cmd(KIND_START, '0, C_MAX, C_MAX, '0);
    send_tick();
    send_tick();
    send_cmd(KIND_START, C_MAX, '0, '0, C_MAX);
    send_tick();
    send_cmd(KIND_START, CB'(5), CB'(7), CB'(2), CB'(9));
    repeat (4) send_tick();
    send_cmd(KIND_START, '0, '0, CB'(3), '0);
    repeat (3) send_tick();
    send_cmd(KIND_START, CB'(10), CB'(10), CB'(10), CB'(13));
    repeat (3) send_tick();
    drain_idle();

    // Random phases, each under its own palette
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_START_COLOR, '0);
          write_reg(REG_LINE_COLOR, '0);
          write_reg(REG_LINE_COLOR + CFG_ADDR_BITS'($urandom_range(1, 14)),
                    COLOR_BITS'($urandom));
        end
        1: begin
          write_reg(REG_START_COLOR, '1);
          write_reg(REG_LINE_COLOR, '1);
        end
        2: begin
          write_reg(REG_START_COLOR, COLOR_BITS'($urandom));
          write_reg(REG_LINE_COLOR, COLOR_BITS'($urandom));
        end
        default: begin
          write_reg(REG_START_COLOR, '1);
          write_reg(REG_LINE_COLOR, '0);
        end
      endcase
      base = cmd_cnt;
      while (cmd_cnt - base < PHASE_CMDS) run_line();
      drain_idle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
